>>> hdl/ic3_pkg.sv
// Shared constants, types and helpers of the 3x3 convolution filter.
`default_nettype none
package ic3_pkg;
    localparam int MaxWidth   = 1024;
    localparam int MaxHeight  = 1024;
    localparam int AddrW      = $clog2(MaxWidth);
    localparam int DimW       = 11;
    localparam int PosW       = 10;
    localparam int SumW       = 20;
    localparam int RegIdxW    = 3;
    localparam int CfgW       = 24;
    localparam int QuoW       = 20;

    localparam logic [RegIdxW-1:0] REG_WIDTH  = 3'd0;
    localparam logic [RegIdxW-1:0] REG_HEIGHT = 3'd1;
    localparam logic [RegIdxW-1:0] REG_DIV    = 3'd2;
    localparam logic [RegIdxW-1:0] REG_COEF0  = 3'd3;
    localparam logic [RegIdxW-1:0] REG_COEF1  = 3'd4;
    localparam logic [RegIdxW-1:0] REG_COEF2  = 3'd5;

    typedef struct packed {
        logic [7:0]     value;
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
        logic           done;
    } result_t;

    typedef struct packed {
        logic [SumW-1:0] sum;
        logic [7:0]      divisor;
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
        logic            done;
    } div_req_t;
endpackage
`default_nettype wire

>>> hdl/ic3_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module ic3_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> hdl/ic3_div.sv
// Iterative signed-by-unsigned divider with truncation toward zero and clamp to 0..255.
`default_nettype none
module ic3_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  ic3_pkg::div_req_t      req,
    output logic                   busy,
    output ic3_pkg::result_t       res
);
    import ic3_pkg::*;

    localparam int CntW = $clog2(QuoW + 1);

    logic [QuoW-1:0] rem_reg, rem_next;
    logic [QuoW-1:0] quo_reg, quo_next;
    logic [7:0]      dv_reg;
    logic            neg_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [PosW-1:0] row_reg, col_reg;
    logic            pd_reg;
    logic [QuoW:0]   trial;
    logic [QuoW-1:0] shifted;

    always_comb
    begin
        shifted  = {rem_reg[QuoW-2:0], quo_reg[QuoW-1]};
        trial    = {1'b0, shifted} - {{(QuoW - 7){1'b0}}, dv_reg};
        rem_next = trial[QuoW] ? shifted : trial[QuoW-1:0];
        quo_next = {quo_reg[QuoW-2:0], ~trial[QuoW]};
        cnt_next = cnt_reg - 1'b1;
        busy_next = busy_reg && (cnt_reg != CntW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(QuoW);
            end
            else if (busy_reg)
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= req.sum[SumW-1];
            quo_reg <= req.sum[SumW-1] ? (~req.sum + 1'b1) : req.sum;
            rem_reg <= '0;
            dv_reg  <= (req.divisor == 8'd0) ? 8'd1 : req.divisor;
            row_reg <= req.row;
            col_reg <= req.col;
            pd_reg  <= req.done;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // A negative quotient clamps to zero; a nonzero magnitude above 255 saturates.
    always_comb
    begin
        res.row  = row_reg;
        res.col  = col_reg;
        res.done = pd_reg;
        if (neg_reg || quo_reg == '0)
        begin
            res.value = 8'd0;
        end
        else if (quo_reg > QuoW'(255))
        begin
            res.value = 8'd255;
        end
        else
        begin
            res.value = quo_reg[7:0];
        end
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

>>> hdl/image_convolution_3x3_clamp.sv
// Top level of the 3x3 convolution filter with divisor and clamp.
//
//  channel   direction  fields (lowest bit first)
//  s_axis    in         tdata: pixel_value[7:0]
//  m_axis    out        tdata: filtered_value[7:0], out_row[17:8], out_col[27:18]; tlast: plane_done
//  cfg       in         cfg_we, cfg_index, cfg_data (width, height, divisor, coef rows)
//
// An interior request passes through the idle state that takes the pixel, a read state
// that reads both line stores (registered read data), a calculate state that writes them
// back and forms the weighted sum, and the divider (20 restoring steps, one quotient bit
// per cycle, then the finished result) before the next pixel is taken.
// A border pixel goes through the idle, read and calculate states and gives no result.
// Reset clears position and window; the line stores are not cleared, a fill count marks
// the columns written since reset and any column at or beyond it reads as zero.
// A result waits in the output register; the next pixel is taken while it waits
// and only blocks if a second result would need the same register.
`default_nettype none
module image_convolution_3x3_clamp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // pixel_value
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // filtered_value, out_row, out_col
    output logic                        m_axis_tlast,   // plane_done
    input  wire logic                   cfg_we,
    input  wire logic [ic3_pkg::RegIdxW-1:0] cfg_index,
    input  wire logic [ic3_pkg::CfgW-1:0]    cfg_data
);
    import ic3_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_DIV   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DimW-1:0] width_reg, height_reg;
    logic [7:0]      div_reg;
    logic [23:0]     coef_reg [3];

    logic [PosW-1:0] row_reg, col_reg;
    logic [7:0]      win_reg [9];
    logic [7:0]      px_reg;
    logic [DimW-1:0] fill_reg;  // columns below this were written since reset

    logic [AddrW-1:0] addr;
    logic             ram_we;
    logic [7:0]       up1_raw, up2_raw, up1, up2;

    logic [DimW-1:0] w_eff, h_eff;
    logic            last_col, last_row, interior;

    logic            res_valid_reg;
    result_t         res_reg;

    logic            div_start, div_busy;
    div_req_t        div_req;
    result_t         div_res;
    logic signed [SumW-1:0] sum;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DimW'(1024);
            height_reg  <= DimW'(1024);
            div_reg     <= 8'd1;
            coef_reg[0] <= 24'd0;
            coef_reg[1] <= 24'd256;
            coef_reg[2] <= 24'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg   <= cfg_data[DimW-1:0];
                REG_HEIGHT: height_reg  <= cfg_data[DimW-1:0];
                REG_DIV:    div_reg     <= cfg_data[7:0];
                REG_COEF0:  coef_reg[0] <= cfg_data;
                REG_COEF1:  coef_reg[1] <= cfg_data;
                REG_COEF2:  coef_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = (width_reg < DimW'(3)) ? DimW'(3)
              : (width_reg > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_reg;
        h_eff = (height_reg < DimW'(3)) ? DimW'(3)
              : (height_reg > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_reg;
        last_col = ({1'b0, col_reg} + DimW'(1)) >= w_eff;
        last_row = ({1'b0, row_reg} + DimW'(1)) >= h_eff;
        interior = (row_reg >= PosW'(2)) && (col_reg >= PosW'(2));
        addr     = col_reg[AddrW-1:0];
        ram_we   = (state_reg == ST_CALC);
        up1      = ({1'b0, col_reg} < fill_reg) ? up1_raw : 8'd0;
        up2      = ({1'b0, col_reg} < fill_reg) ? up2_raw : 8'd0;
    end

    ic3_ram #(.Width(8), .Depth(MaxWidth)) u_store_a (
        .clk(clk), .we(ram_we), .addr(addr), .wdata(px_reg), .rdata(up1_raw));
    ic3_ram #(.Width(8), .Depth(MaxWidth)) u_store_b (
        .clk(clk), .we(ram_we), .addr(addr), .wdata(up1), .rdata(up2_raw));

    // Weighted sum over the window after the shift; new column is up2, up1, px.
    always_comb
    begin
        logic [7:0] nw [9];
        logic signed [SumW-1:0] acc;
        nw[0] = win_reg[1]; nw[1] = win_reg[2]; nw[2] = up2;
        nw[3] = win_reg[4]; nw[4] = win_reg[5]; nw[5] = up1;
        nw[6] = win_reg[7]; nw[7] = win_reg[8]; nw[8] = px_reg;
        acc = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc = acc + SumW'($signed({1'b0, nw[r*3+k]})
                                  * $signed(coef_reg[r][8*k +: 8]));
            end
        end
        sum = acc;
    end

    always_comb
    begin
        div_req.sum     = sum;
        div_req.divisor = div_reg;
        div_req.row     = row_reg - PosW'(1);
        div_req.col     = col_reg - PosW'(1);
        div_req.done    = last_col && last_row;
        div_start       = (state_reg == ST_CALC) && interior;
    end

    ic3_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .req(div_req),
        .busy(div_busy), .res(div_res));

    // The divider holds its result once busy drops, so a full output register
    // simply keeps the request in ST_DIV until the register frees up.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = interior ? ST_DIV : ST_IDLE;
            ST_DIV:  if (!div_busy && (!res_valid_reg || m_axis_tready)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CALC)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up2;
                win_reg[5] <= up1;
                win_reg[8] <= px_reg;
                // Columns are written in order from zero, so the written
                // entries always form a prefix of both stores.
                if ({1'b0, col_reg} >= fill_reg)
                begin
                    fill_reg <= {1'b0, col_reg} + DimW'(1);
                end
                if (last_col)
                begin
                    col_reg   <= '0;
                    row_reg   <= last_row ? '0 : row_reg + PosW'(1);
                end
                else
                begin
                    col_reg <= col_reg + PosW'(1);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DIV && state_next == ST_IDLE)
            begin
                res_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            px_reg <= s_axis_tdata;
        end
        if (state_reg == ST_DIV && state_next == ST_IDLE)
        begin
            res_reg <= div_res;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {4'd0, res_reg.col, res_reg.row, res_reg.value};
    assign m_axis_tlast  = res_reg.done;
endmodule
`default_nettype wire

>>> hdl/ic3_checker.sv
// Port-level checker for the convolution filter, bound to the top level.
`default_nettype none
module ic3_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result dropped while stalled");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:28] == 4'd0)
        else $error("padding bits set");
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:8] != 10'd0 && m_axis_tdata[27:18] != 10'd0)
        else $error("border position reported");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two pixels taken back to back");
endmodule

bind image_convolution_3x3_clamp ic3_checker u_ic3_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast));
`default_nettype wire

>>> tb/sv/image_convolution_3x3_clamp_tb.sv
// Self-checking testbench of the 3x3 convolution filter with divisor and clamp.
`timescale 1ns / 100ps
`default_nettype none
module image_convolution_3x3_clamp_tb;
    import ic3_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int SettleCycles = 40;
    localparam int HoldCycles = 300;

    // Scoreboard: keeps its own copy of the filter state and configuration,
    // works out a filtered pixel for every accepted input pixel that closes an
    // interior window and checks the results that leave the block in order.
    class conv_scoreboard;
        int unsigned img_w, img_h, div_reg;
        logic [23:0] kern [3];
        byte unsigned row_above [MaxWidth];
        byte unsigned row_above2 [MaxWidth];
        byte unsigned win [9];
        int unsigned row_pos, col_pos;
        result_t pending_q[$];
        int errors;

        function new();
            img_w = 1024;
            img_h = 1024;
            div_reg = 1;
            kern[0] = 24'h0;
            kern[1] = 24'h100;
            kern[2] = 24'h0;
            foreach (row_above[i])
            begin
                row_above[i] = 0;
                row_above2[i] = 0;
            end
            foreach (win[i])
                win[i] = 0;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [RegIdxW-1:0] idx, logic [CfgW-1:0] val);
            case (idx)
                REG_WIDTH:  img_w = val[DimW-1:0];
                REG_HEIGHT: img_h = val[DimW-1:0];
                REG_DIV:    div_reg = val[7:0];
                REG_COEF0:  kern[0] = val;
                REG_COEF1:  kern[1] = val;
                REG_COEF2:  kern[2] = val;
                default: ;
            endcase
        endfunction

        function int weight(int kr, int kc);
            byte w;
            w = kern[kr][8*kc +: 8];
            return w;
        endfunction

        // Advance the window by one pixel and queue the filtered value of the
        // pixel one row up and one column left, when that one is interior.
        function void note_pixel(byte unsigned px);
            int unsigned w, h, d, c, r, ci;
            int acc, quo;
            bit last_col, last_row;
            byte unsigned up1, up2;
            result_t res;
            w = (img_w < 3) ? 3 : (img_w > MaxWidth) ? MaxWidth : img_w;
            h = (img_h < 3) ? 3 : (img_h > MaxHeight) ? MaxHeight : img_h;
            d = (div_reg == 0) ? 1 : div_reg;
            c = col_pos;
            r = row_pos;
            ci = (c < MaxWidth) ? c : MaxWidth - 1;
            up1 = row_above[ci];
            up2 = row_above2[ci];
            last_col = (c + 1 >= w);
            last_row = (r + 1 >= h);
            for (int k = 0; k < 3; k++)
            begin
                win[k*3] = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = up2;
            win[5] = up1;
            win[8] = px;
            row_above2[ci] = up1;
            row_above[ci] = px;
            if (r >= 2 && c >= 2)
            begin
                acc = 0;
                for (int kr = 0; kr < 3; kr++)
                    for (int kc = 0; kc < 3; kc++)
                        acc += int'(win[kr*3+kc]) * weight(kr, kc);
                quo = acc / int'(d);
                if (quo < 0)
                    quo = 0;
                if (quo > 255)
                    quo = 255;
                res.value = quo[7:0];
                res.row = PosW'(r - 1);
                res.col = PosW'(c - 1);
                res.done = last_col && last_row;
                pending_q.push_back(res);
            end
            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
        endfunction

        function void check_result(logic [31:0] data, logic last);
            result_t exp_r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual data %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (data[7:0] !== exp_r.value)
            begin
                $display("%0t: filtered_value mismatch: expected %0d, actual %0d",
                         $time, exp_r.value, data[7:0]);
                errors++;
            end
            if (data[17:8] !== exp_r.row)
            begin
                $display("%0t: out_row mismatch: expected %0d, actual %0d",
                         $time, exp_r.row, data[17:8]);
                errors++;
            end
            if (data[27:18] !== exp_r.col)
            begin
                $display("%0t: out_col mismatch: expected %0d, actual %0d",
                         $time, exp_r.col, data[27:18]);
                errors++;
            end
            if (data[31:28] !== 4'd0)
            begin
                $display("%0t: tdata padding mismatch: expected 0, actual %h",
                         $time, data[31:28]);
                errors++;
            end
            if (last !== exp_r.done)
            begin
                $display("%0t: plane_done mismatch: expected %b, actual %b",
                         $time, exp_r.done, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;      // pixel_value
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [31:0] m_axis_tdata;     // filtered_value, out_row, out_col
    logic m_axis_tlast;            // plane_done
    logic cfg_we;
    logic [RegIdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;

    conv_scoreboard sb;
    bit no_idle;          // when set, neither side inserts gaps
    int hold_asked;       // bumped by the stimulus to ask for a long receiver stall
    int hold_done;
    longint cycles;
    int pixels_sent;

    image_convolution_3x3_clamp dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a stuck handshake anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("image_convolution_3x3_clamp verification failed");
            $finish;
        end
    end

    // Result side. Every accepted result is checked at the edge where it is
    // taken; tready may then drop for a random stall. A request from
    // the stimulus turns the next stall into a long one so the output
    // register fills and the block has to stall its pixel input.
    initial
    begin : result_side
        int stall;
        stall = 0;
        hold_done = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_asked != hold_done)
            begin
                hold_done = hold_asked;
                stall = HoldCycles;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one pixel after a random gap and returns at the edge where the
    // block takes it. tvalid stays high straight into the next request when
    // the next gap is zero.
    task automatic send_pixel(input byte unsigned px);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(8'($urandom_range(0, 255)));
    endtask

    // Registers may only change while the block is idle: wait for every
    // expected result, then for a pixel without a result to finish too.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Leaves cfg_we high; end_config lowers it once a batch is written.
    task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [CfgW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic end_config();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(input int w, input int h, input int d,
                           input logic [23:0] k0, input logic [23:0] k1,
                           input logic [23:0] k2);
        wait_idle();
        write_reg(REG_WIDTH, CfgW'(w));
        write_reg(REG_HEIGHT, CfgW'(h));
        write_reg(REG_DIV, CfgW'(d));
        write_reg(REG_COEF0, k0);
        write_reg(REG_COEF1, k1);
        write_reg(REG_COEF2, k2);
        end_config();
    endtask

    task automatic send_const_plane(input int count, input byte unsigned px);
        for (int i = 0; i < count; i++)
            send_pixel(px);
    endtask

    initial
    begin : stimulus
        int w, h, d, n;
        sb = new();
        cycles = 0;
        pixels_sent = 0;
        hold_asked = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Largest positive weights on bright pixels: the sum clamps high.
        set_all(3, 3, 1, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
        send_const_plane(9, 8'hFF);
        // Most negative weights: the sum clamps to zero.
        set_all(3, 3, 255, 24'h808080, 24'h808080, 24'h808080);
        send_const_plane(9, 8'hFF);
        // Width and height below the minimum act as 3, zero divisor acts as 1,
        // and a mixed kernel on an all-dark plane.
        set_all(0, 2, 0, 24'h80_7F_01, 24'hFF_00_81, 24'h7F_80_02);
        send_const_plane(9, 8'h00);
        // Negative sum truncated toward zero by the divisor.
        set_all(1, 0, 7, 24'hFF_FF_FF, 24'hFE_01_FF, 24'h00_00_00);
        send_random(9);

        // Width register above the maximum; the row is cut short and the next
        // settings take over mid-row with the position kept.
        set_all(2047, 3, 3, 24'h01_02_01, 24'h02_04_02, 24'h01_02_01);
        send_random(200);

        // A long receiver stall while a small plane streams in: the output
        // register fills, the divider holds a second result and the input stalls.
        set_all(4, 4, 1, 24'h00_00_00, 24'h00_01_00, 24'h00_00_00);
        hold_asked++;
        send_random(16);

        // Random planes.
        n = pixels_sent;
        while (n < 1300)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1000, 2047) : $urandom_range(0, 8);
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
            set_all(w, h, d, 24'($urandom_range(0, 24'hFFFFFF)),
                    24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
            w = (w < 3) ? 3 : (w > 12) ? 12 : w;
            h = (h < 3) ? 3 : (h > 8) ? 8 : h;
            // Tall or wide planes are cut short; the next settings take over
            // mid-plane with the position kept.
            if (sb.img_w > 12 || sb.img_h > 8 || $urandom_range(0, 5) == 0)
                send_random($urandom_range(1, 40));
            else
                send_random(w * h * $urandom_range(1, 2));
            n = pixels_sent;
        end

        no_idle = 1'b0;
        wait_idle();
        if (sb.errors == 0)
            $display("image_convolution_3x3_clamp verification clean");
        else
            $display("image_convolution_3x3_clamp verification failed");
        $finish;
    end
endmodule
`default_nettype wire
